// File: hdl/perlin_noise_2d_top_macros.svh
// ----------------------------------------------------------------------------
// perlin_noise_2d_top_macros
// Assertion macros used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_2D_TOP_MACROS_SVH
`define PERLIN_NOISE_2D_TOP_MACROS_SVH

// Check that an antecedent implies a consequent in the next cycle.
`define PN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define PN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/pn2d_pkg.sv
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared constants and the quarter-wave sine function for the noise block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pn2d_pkg;

   localparam logic [31:0] HASH_MUL_A  = 32'd3284157443;
   localparam logic [31:0] HASH_MUL_B  = 32'd1911520717;
   localparam logic [31:0] HASH_MUL_C  = 32'd2048419325;
   localparam longint      HALF_PI_Q30 = 64'sd1686629713;

   // long division of non-negative values, elaboration only
   function automatic longint udiv(input longint num, input longint den);
      longint quo;
      longint rem;
      quo = 0;
      rem = 0;
      for (int b = 62; b >= 0; b--) begin
         rem = (rem << 1) | ((num >>> b) & 64'sd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (longint'(1) << b);
         end
      end
      udiv = quo;
   endfunction

   // quarter sine in Q1.14, evaluated at elaboration for constant tables
   function automatic logic [15:0] quarter_sine(input int unsigned idx, input int unsigned steps);
      longint theta;
      longint term;
      longint sum;
      longint den;
      theta = udiv(HALF_PI_Q30 * longint'(idx), longint'(steps));
      term  = theta;
      sum   = theta;
      for (int n = 1; n <= 8; n++) begin
         term = (term * theta) >>> 30;
         term = (term * theta) >>> 30;
         den  = longint'(2 * n) * longint'(2 * n + 1);
         term = udiv(term, den);
         if ((n & 1) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      quarter_sine = 16'((sum + 32768) >>> 16);
   endfunction

   function automatic logic [31:0] rot16(input logic [31:0] v);
      rot16 = {v[15:0], v[31:16]};
   endfunction

endpackage
`default_nettype wire

// File: hdl/pn2d_corner.sv
// ----------------------------------------------------------------------------
// pn2d_corner
// Hash of one cell corner, gradient lookup and dot product with the offset.
// Five register stages; the enable stalls every stage at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pn2d_corner #(
   parameter int FRAC_BITS  = 8,
   parameter int ANGLE_BITS = 10,
   localparam int OFF_W = FRAC_BITS + 2,
   localparam int DOT_W = FRAC_BITS + 18
) (
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  wire logic [31:0]             cx,
   input  wire logic [31:0]             cy,
   input  wire logic signed [OFF_W-1:0] dx,
   input  wire logic signed [OFF_W-1:0] dy,
   output logic signed [DOT_W-1:0]      dot
);
   localparam int QS   = 1 << (ANGLE_BITS - 2);
   localparam int QS_W = ANGLE_BITS - 2;

   logic [15:0] sine_rom [0:QS];
   always_comb begin
      for (int i = 0; i <= QS; i++) begin
         sine_rom[i] = pn2d_pkg::quarter_sine(i, QS);
      end
   end

   logic [31:0] a1_ff, b1_ff, a2_ff, b2_ff, a3_ff, a4_ff;
   logic signed [OFF_W-1:0] dx_ff [0:4];
   logic signed [OFF_W-1:0] dy_ff [0:4];
   logic signed [16:0] gx_ff, gy_ff;
   logic [31:0] b2_in, a3_in;
   logic [ANGLE_BITS-1:0] k;
   logic [1:0] quad;
   logic [QS_W-1:0] r;
   logic signed [16:0] s_r, s_c, gx_in, gy_in;

   assign b2_in = (b1_ff ^ pn2d_pkg::rot16(a1_ff)) * pn2d_pkg::HASH_MUL_B;
   assign a3_in = (a2_ff ^ pn2d_pkg::rot16(b2_ff)) * pn2d_pkg::HASH_MUL_C;
   assign k     = a4_ff[31 -: ANGLE_BITS];
   assign quad  = k[ANGLE_BITS-1 -: 2];
   assign r     = k[QS_W-1:0];
   assign s_r   = 17'(signed'({1'b0, sine_rom[r]}));
   assign s_c   = 17'(signed'({1'b0, sine_rom[(QS_W+1)'(QS) - {1'b0, r}]}));

   always_comb begin
      case (quad)
         2'd0: begin gx_in = s_c;  gy_in = s_r;  end
         2'd1: begin gx_in = -s_r; gy_in = s_c;  end
         2'd2: begin gx_in = -s_c; gy_in = -s_r; end
         default: begin gx_in = s_r; gy_in = -s_c; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a1_ff <= cx * pn2d_pkg::HASH_MUL_A;
         b1_ff <= cy;
         b2_ff <= b2_in;
         a2_ff <= a1_ff;
         a4_ff <= a3_in;
         a3_ff <= a3_in;
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         dot   <= DOT_W'(dx_ff[3] * gx_ff) + DOT_W'(dy_ff[3] * gy_ff);
         dx_ff[0] <= dx;
         dy_ff[0] <= dy;
         for (int i = 1; i < 5; i++) begin
            dx_ff[i] <= dx_ff[i-1];
            dy_ff[i] <= dy_ff[i-1];
         end
      end
   end

   logic unused_ok;
   assign unused_ok = ^{a3_ff, dx_ff[4], dy_ff[4]};
endmodule
`default_nettype wire

// File: hdl/pn2d_blend.sv
// ----------------------------------------------------------------------------
// pn2d_blend
// Blend four corner dot products in x, then y, round and clamp to Q1.14.
// Three register stages sharing the stall enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pn2d_blend #(
   parameter int FRAC_BITS = 8,
   localparam int DOT_W = FRAC_BITS + 18
) (
   input  wire logic                    clock,
   input  wire logic                    enable,
   input  wire logic signed [DOT_W-1:0] n00,
   input  wire logic signed [DOT_W-1:0] n10,
   input  wire logic signed [DOT_W-1:0] n01,
   input  wire logic signed [DOT_W-1:0] n11,
   input  wire logic [FRAC_BITS-1:0]    fx,
   input  wire logic [FRAC_BITS-1:0]    fy,
   output logic signed [15:0]           noise
);
   localparam int W = DOT_W + FRAC_BITS + 3;

   logic signed [DOT_W-1:0] top_ff, bot_ff, v_ff;
   logic [FRAC_BITS-1:0] fy_ff;
   logic signed [W-1:0] pt, pb, pv, rv;
   logic signed [DOT_W-1:0] top_in, bot_in, v_in;

   assign pt = (W'(n10) - W'(n00)) * W'(signed'({1'b0, fx}));
   assign pb = (W'(n11) - W'(n01)) * W'(signed'({1'b0, fx}));
   assign top_in = n00 + DOT_W'(pt >>> FRAC_BITS);
   assign bot_in = n01 + DOT_W'(pb >>> FRAC_BITS);
   assign pv = (W'(bot_ff) - W'(top_ff)) * W'(signed'({1'b0, fy_ff}));
   assign v_in = top_ff + DOT_W'(pv >>> FRAC_BITS);
   assign rv = (W'(v_ff) + W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (enable) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         fy_ff  <= fy;
         v_ff   <= v_in;
         if (rv > W'(16384)) begin
            noise <= 16'sd16384;
         end else if (rv < -W'(16384)) begin
            noise <= -16'sd16384;
         end else begin
            noise <= 16'(rv);
         end
      end
   end
endmodule
`default_nettype wire

// File: hdl/perlin_noise_2d_top.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d_top
// Two-dimensional gradient noise, one sample word in and one noise word out.
// ----------------------------------------------------------------------------
// One point is accepted every clock while rsp_tready is high. The stages are
// one input split stage, five hash and dot stages in the four corner units,
// three blend and round stages. All stages advance together on one enable;
// the output register frees as soon as it is taken or empty.
`timescale 1ns / 1ps
`default_nettype none
`include "perlin_noise_2d_top_macros.svh"
module perlin_noise_2d_top #(
   parameter int FRAC_BITS  = 8,
   parameter int ANGLE_BITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // x_coord[23:0], y_coord[47:24]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // noise_value[15:0]
);
   localparam int OFF_W = FRAC_BITS + 2;
   localparam int DOT_W = FRAC_BITS + 18;
   localparam int LAT   = 9;

   logic enable;
   logic [LAT-1:0] vld_ff;
   logic [31:0] x0_ff, y0_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic [FRAC_BITS-1:0] fxd_ff [0:4];
   logic [FRAC_BITS-1:0] fyd_ff [0:4];
   logic signed [OFF_W-1:0] dx0, dy0, dx1, dy1;
   logic signed [DOT_W-1:0] n00, n10, n01, n11;
   logic signed [23:0] xs, ys;

   assign enable     = rsp_tready | ~vld_ff[LAT-1];
   assign req_tready = enable;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign xs = signed'(req_tdata[23:0]);
   assign ys = signed'(req_tdata[47:24]);
   assign dx0 = OFF_W'(signed'({1'b0, fx_ff}));
   assign dy0 = OFF_W'(signed'({1'b0, fy_ff}));
   assign dx1 = dx0 - OFF_W'(1 << FRAC_BITS);
   assign dy1 = dy0 - OFF_W'(1 << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x0_ff <= 32'(xs >>> FRAC_BITS);
         y0_ff <= 32'(ys >>> FRAC_BITS);
         fx_ff <= req_tdata[FRAC_BITS-1:0];
         fy_ff <= req_tdata[24 +: FRAC_BITS];
         fxd_ff[0] <= fx_ff;
         fyd_ff[0] <= fy_ff;
         for (int i = 1; i < 5; i++) begin
            fxd_ff[i] <= fxd_ff[i-1];
            fyd_ff[i] <= fyd_ff[i-1];
         end
      end
   end

   pn2d_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c00 (
      .clock(clock), .enable(enable), .cx(x0_ff), .cy(y0_ff),
      .dx(dx0), .dy(dy0), .dot(n00));
   pn2d_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c10 (
      .clock(clock), .enable(enable), .cx(x0_ff + 32'd1), .cy(y0_ff),
      .dx(dx1), .dy(dy0), .dot(n10));
   pn2d_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c01 (
      .clock(clock), .enable(enable), .cx(x0_ff), .cy(y0_ff + 32'd1),
      .dx(dx0), .dy(dy1), .dot(n01));
   pn2d_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c11 (
      .clock(clock), .enable(enable), .cx(x0_ff + 32'd1), .cy(y0_ff + 32'd1),
      .dx(dx1), .dy(dy1), .dot(n11));

   pn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock(clock), .enable(enable), .n00(n00), .n10(n10), .n01(n01), .n11(n11),
      .fx(fxd_ff[4]), .fy(fyd_ff[4]), .noise(rsp_tdata));

   `PN_ASSERT_NEXT(a_hold_out, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `PN_ASSERT_NEXT(a_advance, clock, reset, req_tvalid && req_tready, vld_ff[0])
   `PN_ASSERT_NOW(a_range, clock, reset, rsp_tvalid,
      $signed(rsp_tdata) <= 16'sd16384 && $signed(rsp_tdata) >= -16'sd16384)
endmodule
`default_nettype wire

// File: verif/tb_perlin_noise_2d_top.sv
// ----------------------------------------------------------------------------
// tb_perlin_noise_2d_top
// Streams fixed-point sample points into the noise block and checks every
// noise word against a predictor built from the hash, gradient and blend math.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_perlin_noise_2d_top;

   localparam int FRAC = 8;
   localparam int ANG = 10;
   localparam int QSTEPS = 1 << (ANG - 2);
   localparam int LATENCY = 9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;   // x_coord[23:0], y_coord[47:24]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // noise_value[15:0]

   logic signed [15:0] noise_expected[$];
   longint sine_lut[0:QSTEPS];
   int mismatches = 0;
   int burst_left = 0;
   bit stall_enable = 1'b1;

   perlin_noise_2d_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint floor_div_pow2(longint v, int s);
      floor_div_pow2 = v >>> s;
   endfunction

   function automatic longint sine_q14(int i);
      longint theta;
      longint term;
      longint acc;
      theta = 64'sd1686629713 * longint'(i) / longint'(QSTEPS);
      term = theta;
      acc = theta;
      for (int n = 1; n <= 8; n++) begin
         term = (term * theta) >>> 30;
         term = (term * theta) >>> 30;
         term = term / (longint'(2 * n) * longint'(2 * n + 1));
         if (n % 2 == 1) begin
            acc -= term;
         end else begin
            acc += term;
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      sine_q14 = (acc + 32768) >>> 16;
   endfunction

   function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                         longint dx, longint dy);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] k;
      int quad;
      int r;
      longint gx;
      longint gy;
      a = cx * pn2d_pkg::HASH_MUL_A;
      b = cy ^ {a[15:0], a[31:16]};
      b = b * pn2d_pkg::HASH_MUL_B;
      a = a ^ {b[15:0], b[31:16]};
      a = a * pn2d_pkg::HASH_MUL_C;
      k = a >> (32 - ANG);
      quad = int'((k >> (ANG - 2)) & 3);
      r = int'(k & (QSTEPS - 1));
      case (quad)
         0: begin gx = sine_lut[QSTEPS - r]; gy = sine_lut[r]; end
         1: begin gx = -sine_lut[r]; gy = sine_lut[QSTEPS - r]; end
         2: begin gx = -sine_lut[QSTEPS - r]; gy = -sine_lut[r]; end
         default: begin gx = sine_lut[r]; gy = -sine_lut[QSTEPS - r]; end
      endcase
      corner_dot = dx * gx + dy * gy;
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      blend = a + floor_div_pow2((b - a) * w, FRAC);
   endfunction

   function automatic logic signed [15:0] predict_noise(logic [23:0] xr, logic [23:0] yr);
      int x;
      int y;
      logic [31:0] x0;
      logic [31:0] y0;
      longint one;
      longint fx;
      longint fy;
      longint top_row;
      longint bot_row;
      longint v;
      x = int'(signed'(xr));
      y = int'(signed'(yr));
      x0 = x >>> FRAC;
      y0 = y >>> FRAC;
      one = longint'(1) << FRAC;
      fx = x & (one - 1);
      fy = y & (one - 1);
      top_row = blend(corner_dot(x0, y0, fx, fy),
                      corner_dot(x0 + 1, y0, fx - one, fy), fx);
      bot_row = blend(corner_dot(x0, y0 + 1, fx, fy - one),
                      corner_dot(x0 + 1, y0 + 1, fx - one, fy - one), fx);
      v = blend(top_row, bot_row, fy);
      v = floor_div_pow2(v + (one >> 1), FRAC);
      if (v > 16384) begin
         v = 16384;
      end
      if (v < -16384) begin
         v = -16384;
      end
      predict_noise = 16'(v);
   endfunction

   // hold the word until taken; bursts with random gaps
   task automatic send_point(logic [23:0] xv, logic [23:0] yv);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {yv, xv};
      noise_expected.push_back(predict_noise(xv, yv));
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      burst_left--;
   endtask

   task automatic finish_stream();
      req_tvalid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (stall_enable) begin
            rsp_tready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 1) == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (noise_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected noise word %0d", $signed(rsp_tdata));
            end
         end else begin
            want = noise_expected.pop_front();
            if (rsp_tdata !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("noise_value mismatch: expected %0d, actual %0d",
                           want, $signed(rsp_tdata));
               end
            end
         end
      end
   end

   task automatic test_extremes();
      logic [23:0] edges[8] = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF,
                               24'h0000FF, 24'hFFFF00, 24'h000100, 24'h800100};
      for (int i = 0; i < 8; i++) begin
         send_point(edges[i], edges[(i * 3 + 1) % 8]);
      end
   endtask

   task automatic test_negative_cells();
      for (int i = 0; i < 8; i++) begin
         send_point(24'(-i * 37 - 1), 24'(-i * 91 - 200));
      end
   endtask

   task automatic test_random_points();
      for (int i = 0; i < 1000; i++) begin
         send_point(24'($urandom), 24'($urandom));
      end
   endtask

   task automatic test_local_walk();
      logic [23:0] bx;
      logic [23:0] by;
      for (int j = 0; j < 20; j++) begin
         bx = 24'($urandom);
         by = 24'($urandom);
         for (int i = 0; i < 40; i++) begin
            send_point(bx + 24'($urandom_range(0, 767)), by + 24'($urandom_range(0, 767)));
         end
      end
   endtask

   task automatic test_no_stall();
      stall_enable = 1'b0;
      for (int i = 0; i < 40; i++) begin
         send_point(24'($urandom), 24'($urandom));
      end
      stall_enable = 1'b1;
   endtask

   initial begin
      for (int i = 0; i <= QSTEPS; i++) begin
         sine_lut[i] = sine_q14(i);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_negative_cells();
      test_random_points();
      test_local_walk();
      test_no_stall();
      finish_stream();
      while (noise_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

// File: perlin_noise_2d_top.f
+incdir+hdl
hdl/pn2d_pkg.sv
hdl/pn2d_corner.sv
hdl/pn2d_blend.sv
hdl/perlin_noise_2d_top.sv
verif/tb_perlin_noise_2d_top.sv
